// ===== rtl/mbde_pkg.sv =====
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared types and constants of the multi-button debounce and edge core.
// ----------------------------------------------------------------------------
package mbde_pkg;

  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned TIME_W       = 8;
  localparam int unsigned CD_W         = 10;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned INPUT_LIMIT  = 8;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_QUERY    = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_RESERVED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    TR_IDLE    = 2'd0,
    TR_PRESSED = 2'd1,
    TR_RISE    = 2'd2,
    TR_FALL    = 2'd3
  } transition_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEP_TIME    = 3'd0,
    REG_PRESS_TIME   = 3'd1,
    REG_RELEASE_TIME = 3'd2,
    REG_CHAN_COUNT   = 3'd3,
    REG_ACTIVE_MASK  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [CD_W-1:0] countdown;
    logic                   stable;
    logic                   pressed;
    logic                   request;
  } step_result_t;

endpackage

// ===== rtl/multi_button_debounce_edge_core.sv =====
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_core
// Per-channel debounce countdowns with press/release classification and a
// latched change request.
// ----------------------------------------------------------------------------
// A tick sweeps the n channels in use (channel_count capped at 8 and at
// CHANNELS), one shared countdown unit updating one channel per cycle, and
// then loads its result into the output register; a query, a clear, an
// unused action or a tick with n zero loads its result without a sweep. The
// input side is ready only while no item is in work; a finished result waits
// in the output register, so the next item can be accepted before it is
// taken. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_core
  import mbde_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // raw_levels[7:0], channel[10:8], zero
  input  logic [1:0]           s_tuser,   // action[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // transition[1:0], request_pending[2],
                                          // channel_valid[3], zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MAX_USED = (CHANNELS < INPUT_LIMIT) ? CHANNELS : INPUT_LIMIT;

  state_t state;
  state_t state_next;

  logic [TIME_W-1:0]  step_size;
  logic [TIME_W-1:0]  press_time;
  logic [TIME_W-1:0]  release_time;
  logic [CNT_W-1:0]   channel_count;
  logic [LEVEL_W-1:0] active_high_mask;

  logic signed [CD_W-1:0] countdown [CHANNELS];
  logic [CHANNELS-1:0]    stable_level;
  logic [CHANNELS-1:0]    pressed_now;
  logic [CHANNELS-1:0]    pressed_before;
  logic                   change_request;

  action_t            action;
  logic [LEVEL_W-1:0] raw_levels;
  logic [CHAN_W-1:0]  channel;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   idx;

  logic [CNT_W-1:0]   used_in;
  logic               in_accept;
  logic               load;
  logic               channel_valid;
  logic [IDX_W-1:0]   run_idx;
  logic [IDX_W-1:0]   query_idx;
  logic               query_hit;
  transition_t        transition;
  logic               request_next;
  step_result_t       step_res;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign load      = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign run_idx   = IDX_W'(idx);
  assign query_idx = IDX_W'(channel);

  always_comb begin
    used_in = channel_count;
    if (used_in > CNT_W'(MAX_USED)) begin
      used_in = CNT_W'(MAX_USED);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if ((action_t'(s_tuser) == ACT_TICK) && (used_in != '0)) begin
            state_next = ST_RUN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (idx == used - CNT_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  mbde_step_unit u_step (
    .countdown      (countdown[run_idx]),
    .stable         (stable_level[run_idx]),
    .raw            (raw_levels[idx[CHAN_W-1:0]]),
    .active_high    (active_high_mask[idx[CHAN_W-1:0]]),
    .pressed_before (pressed_before[run_idx]),
    .step_size      (step_size),
    .press_time     (press_time),
    .release_time   (release_time),
    .result         (step_res)
  );

  always_comb begin
    channel_valid = {1'b0, channel} < used;
    query_hit     = (action == ACT_QUERY) && change_request && channel_valid;
    transition    = TR_IDLE;
    if (query_hit) begin
      case ({pressed_now[query_idx], pressed_before[query_idx]})
        2'b11:   transition = TR_PRESSED;
        2'b10:   transition = TR_RISE;
        2'b01:   transition = TR_FALL;
        default: transition = TR_IDLE;
      endcase
    end
    request_next = (action == ACT_CLEAR) ? 1'b0 : change_request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= TIME_W'(1);
      press_time       <= '0;
      release_time     <= '0;
      channel_count    <= '0;
      active_high_mask <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        countdown[i] <= '0;
      end
      stable_level     <= '0;
      pressed_now      <= '0;
      pressed_before   <= '0;
      change_request   <= 1'b0;
      m_tvalid         <= 1'b0;
      idx              <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STEP_TIME:    step_size <= (cfg_data == '0) ? TIME_W'(1) : cfg_data;
          REG_PRESS_TIME:   press_time <= cfg_data;
          REG_RELEASE_TIME: release_time <= cfg_data;
          REG_CHAN_COUNT:   channel_count <= cfg_data[CNT_W-1:0];
          REG_ACTIVE_MASK:  active_high_mask <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        idx <= '0;
      end else if (state == ST_RUN) begin
        countdown[run_idx]    <= step_res.countdown;
        stable_level[run_idx] <= step_res.stable;
        pressed_now[run_idx]  <= step_res.pressed;
        if (step_res.request) begin
          change_request <= 1'b1;
        end
        idx <= idx + CNT_W'(1);
      end

      if (load) begin
        change_request <= request_next;
        if (query_hit) begin
          pressed_before[query_idx] <= pressed_now[query_idx];
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action     <= action_t'(s_tuser);
      raw_levels <= s_tdata[LEVEL_W-1:0];
      channel    <= s_tdata[LEVEL_W+CHAN_W-1:LEVEL_W];
      used       <= used_in;
    end
    if (load) begin
      m_tdata <= {4'b0000, channel_valid, request_next, transition};
    end
  end

`ifndef SYNTHESIS
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (idx < used))
    else $error("channel sweep past channel count");

  a_edge_needs_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] == TR_IDLE) || m_tdata[3]))
    else $error("transition reported for invalid channel");

  a_clear_drops_flag: assert property (@(posedge clk) disable iff (rst)
    (load && (action == ACT_CLEAR)) |=> (!change_request && !m_tdata[2]))
    else $error("clear did not drop the request flag");

  a_flag_rises_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(change_request) |-> ($past(state) == ST_RUN))
    else $error("request flag set outside a tick sweep");
`endif

endmodule

// ===== rtl/mbde_step_unit.sv =====
// ----------------------------------------------------------------------------
// mbde_step_unit
// Shared countdown update for one channel per cycle: subtract, expiry
// compare, level acceptance and reload selection.
// ----------------------------------------------------------------------------
module mbde_step_unit
  import mbde_pkg::*;
(
  input  logic signed [CD_W-1:0]   countdown,
  input  logic                     stable,
  input  logic                     raw,
  input  logic                     active_high,
  input  logic                     pressed_before,
  input  logic        [TIME_W-1:0] step_size,
  input  logic        [TIME_W-1:0] press_time,
  input  logic        [TIME_W-1:0] release_time,
  output step_result_t             result
);

  logic signed [CD_W:0] diff;
  logic                 running;
  logic                 expired;
  logic                 stable_new;
  logic                 pressed_new;

  always_comb begin
    diff        = $signed({countdown[CD_W-1], countdown})
                - $signed({{(CD_W + 1 - TIME_W){1'b0}}, step_size});
    running     = raw != stable;
    expired     = running && (diff[CD_W] || (diff == '0));
    stable_new  = expired ? raw : stable;
    pressed_new = stable_new == active_high;

    result.stable  = stable_new;
    result.pressed = pressed_new;
    result.request = pressed_new != pressed_before;
    if (!running || expired) begin
      if (pressed_new) begin
        result.countdown = $signed({{(CD_W - TIME_W){1'b0}}, release_time});
      end else begin
        result.countdown = $signed({{(CD_W - TIME_W){1'b0}}, press_time});
      end
    end else begin
      result.countdown = diff[CD_W-1:0];
    end
  end

endmodule
